/* hdl/mdu_pkg.sv */
// Shared types, codes and helper functions for the multiply/divide unit.
// No dependencies; used by every mdu module except mdu_checker.
`default_nettype none

package mdu_pkg;

    typedef enum logic [1:0] {
        ACT_MULU = 2'd0,
        ACT_MULS = 2'd1,
        ACT_DIVU = 2'd2,
        ACT_DIVS = 2'd3
    } mdu_action_t;

    localparam logic [1:0] WSEL_8   = 2'd0;
    localparam logic [1:0] WSEL_16  = 2'd1;
    localparam logic [1:0] WSEL_32  = 2'd2;
    // spare select code, decodes as 32 bits
    localparam logic [1:0] WSEL_ALT = 2'd3;

    localparam int DIV_STEPS = 32;

    // control carried alongside the datapath
    typedef struct packed {
        logic        is_div;
        logic        is_signed;
        logic [1:0]  wsel;
        logic        pre_err;
        logic        neg_n;
        logic        neg_d;
        logic [31:0] raw_lo;
        logic [31:0] raw_hi;
    } mdu_ctl_t;

    // classified request, front to back
    typedef struct packed {
        mdu_ctl_t    ctl;
        logic [63:0] n;
        logic [31:0] d;
        logic [32:0] mul_a;
        logic [32:0] mul_b;
    } mdu_item_t;

    typedef struct packed {
        logic        valid;
        mdu_ctl_t    ctl;
        logic [63:0] acc;
        logic [31:0] d;
    } mdu_stage_t;

    function automatic logic [31:0] width_mask(input logic [1:0] wsel);
        logic [31:0] m;
        unique case (wsel)
            WSEL_8:  m = 32'h0000_00FF;
            WSEL_16: m = 32'h0000_FFFF;
            default: m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

    function automatic logic top_bit(input logic [31:0] x, input logic [1:0] wsel);
        logic b;
        unique case (wsel)
            WSEL_8:  b = x[7];
            WSEL_16: b = x[15];
            default: b = x[31];
        endcase
        return b;
    endfunction

    // one restoring step: acc = {partial remainder, dividend bits / quotient bits}
    function automatic logic [63:0] div_step(input logic [63:0] acc, input logic [31:0] d);
        logic [32:0] t;
        logic [32:0] diff;
        logic [63:0] r;
        t    = {acc[63:32], acc[31]};
        diff = t - {1'b0, d};
        if (t >= {1'b0, d}) begin
            r = {diff[31:0], acc[30:0], 1'b1};
        end else begin
            r = {t[31:0], acc[30:0], 1'b0};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* hdl/mdu_front.sv */
// Front end: masks operands to width, builds dividend/divisor magnitudes,
// flags zero divisor and early quotient overflow. Uses mdu_pkg.
`default_nettype none

module mdu_front
    import mdu_pkg::*;
(
    input  wire logic [1:0]  action,
    input  wire logic [1:0]  wsel,
    input  wire logic [31:0] src,
    input  wire logic [31:0] acc_lo,
    input  wire logic [31:0] acc_hi,
    output mdu_item_t        item
);

    logic [31:0] m;
    logic [31:0] s_m;
    logic [31:0] lo_m;
    logic [31:0] hi_m;
    logic [63:0] n_raw;
    logic [63:0] m2;
    logic [63:0] n_neg;
    logic [63:0] mag_n;
    logic [31:0] mag_d;
    logic        sgn;
    logic        neg_n;
    logic        neg_d;
    logic        n_top;

    always_comb begin
        m    = width_mask(wsel);
        s_m  = src & m;
        lo_m = acc_lo & m;
        hi_m = acc_hi & m;
        sgn  = (action == ACT_MULS) || (action == ACT_DIVS);
        unique case (wsel)
            WSEL_8: begin
                n_raw = {48'd0, hi_m[7:0], lo_m[7:0]};
                m2    = 64'h0000_0000_0000_FFFF;
                n_top = hi_m[7];
            end
            WSEL_16: begin
                n_raw = {32'd0, hi_m[15:0], lo_m[15:0]};
                m2    = 64'h0000_0000_FFFF_FFFF;
                n_top = hi_m[15];
            end
            default: begin
                n_raw = {hi_m, lo_m};
                m2    = 64'hFFFF_FFFF_FFFF_FFFF;
                n_top = hi_m[31];
            end
        endcase
        neg_n = sgn && n_top;
        neg_d = sgn && top_bit(s_m, wsel);
        n_neg = (~n_raw + 64'd1) & m2;
        mag_n = neg_n ? n_neg : n_raw;
        mag_d = neg_d ? ((~s_m + 32'd1) & m) : s_m;

        item.ctl.is_div    = action[1];
        item.ctl.is_signed = sgn;
        item.ctl.wsel      = wsel;
        // quotient must fit 32 bits before the 32-step divider can run
        item.ctl.pre_err   = (s_m == 32'd0) || (mag_n[63:32] >= mag_d);
        item.ctl.neg_n     = neg_n;
        item.ctl.neg_d     = neg_d;
        item.ctl.raw_lo    = acc_lo;
        item.ctl.raw_hi    = acc_hi;
        item.n             = mag_n;
        item.d             = mag_d;
        item.mul_a         = {sgn && top_bit(lo_m, wsel), lo_m};
        item.mul_b         = {sgn && top_bit(s_m, wsel), s_m};
        // sign extension above the width
        if (sgn && top_bit(lo_m, wsel)) begin
            item.mul_a = {1'b1, lo_m | ~m};
        end
        if (sgn && top_bit(s_m, wsel)) begin
            item.mul_b = {1'b1, s_m | ~m};
        end
    end

endmodule

`default_nettype wire

/* hdl/mdu_queue.sv */
// Two-entry request queue between front and back end.
// Uses mdu_pkg for the item type.
`default_nettype none

module mdu_queue
    import mdu_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      wr_en,
    input  mdu_item_t      wr_item,
    output logic           full,
    input  wire logic      rd_en,
    output logic           rd_valid,
    output mdu_item_t      rd_item
);

    mdu_item_t   slot_reg [0:1];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        do_wr;
    logic        do_rd;

    assign full     = (count_reg == 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_item  = slot_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;

    always_comb begin
        wr_ptr_next = do_wr ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_rd ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_wr} - {1'b0, do_rd};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            slot_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

`default_nettype wire

/* hdl/mdu_back.sv */
// Back end: multiply stage, 32 pipelined restoring-divide stages,
// result formatting and output register. Uses mdu_pkg.
`default_nettype none

module mdu_back
    import mdu_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        in_valid,
    input  mdu_item_t        in_item,
    output logic             in_pop,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      out_lo,
    output logic [31:0]      out_hi,
    output logic             out_sig,
    output logic             out_err
);

    mdu_stage_t  stage_reg  [0:DIV_STEPS];
    mdu_stage_t  stage_next [0:DIV_STEPS];
    logic        adv;
    logic        valid_reg;
    logic [31:0] lo_reg;
    logic [31:0] hi_reg;
    logic        sig_reg;
    logic        err_reg;
    logic [31:0] lo_next;
    logic [31:0] hi_next;
    logic        sig_next;
    logic        err_next;
    logic [65:0] prod;

    // whole pipe moves together; bubbles flow through
    assign adv    = !valid_reg || out_ready;
    assign in_pop = adv && in_valid;

    always_comb begin
        prod = $signed(in_item.mul_a) * $signed(in_item.mul_b);
        stage_next[0].valid = in_valid;
        stage_next[0].ctl   = in_item.ctl;
        stage_next[0].d     = in_item.d;
        stage_next[0].acc   = in_item.ctl.is_div ? in_item.n : prod[63:0];
        for (int i = 1; i <= DIV_STEPS; i++) begin
            stage_next[i]     = stage_reg[i-1];
            stage_next[i].acc = stage_reg[i-1].ctl.is_div
                              ? div_step(stage_reg[i-1].acc, stage_reg[i-1].d)
                              : stage_reg[i-1].acc;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i <= DIV_STEPS; i++) begin
            if (!aresetn) begin
                stage_reg[i].valid <= 1'b0;
            end else if (adv) begin
                stage_reg[i] <= stage_next[i];
            end
        end
    end

    // result formatting from the last divide stage
    mdu_stage_t  fin;
    logic [31:0] m;
    logic [31:0] half;
    logic [31:0] lim;
    logic [31:0] uq;
    logic [31:0] ur;
    logic [31:0] r_lo;
    logic [31:0] r_hi;
    logic        neg_q;
    logic        ovf;

    always_comb begin
        fin   = stage_reg[DIV_STEPS];
        m     = width_mask(fin.ctl.wsel);
        half  = (m >> 1) + 32'd1;
        uq    = fin.acc[31:0];
        ur    = fin.acc[63:32];
        neg_q = fin.ctl.neg_n ^ fin.ctl.neg_d;
        lim   = fin.ctl.is_signed ? (neg_q ? half : half - 32'd1) : m;
        ovf   = uq > lim;
        lo_next  = 32'd0;
        hi_next  = 32'd0;
        sig_next = 1'b0;
        err_next = 1'b0;
        r_lo = fin.acc[31:0] & m;
        unique case (fin.ctl.wsel)
            WSEL_8:  r_hi = {24'd0, fin.acc[15:8]};
            WSEL_16: r_hi = {16'd0, fin.acc[31:16]};
            default: r_hi = fin.acc[63:32];
        endcase
        if (!fin.ctl.is_div) begin
            lo_next  = r_lo;
            hi_next  = r_hi;
            sig_next = fin.ctl.is_signed
                     ? (r_hi != (top_bit(r_lo, fin.ctl.wsel) ? m : 32'd0))
                     : (r_hi != 32'd0);
        end else if (fin.ctl.pre_err || ovf) begin
            lo_next  = fin.ctl.raw_lo;
            hi_next  = fin.ctl.raw_hi;
            err_next = 1'b1;
        end else begin
            lo_next = (neg_q ? (~uq + 32'd1) : uq) & m;
            hi_next = (fin.ctl.neg_n ? (~ur + 32'd1) : ur) & m;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= fin.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            lo_reg  <= lo_next;
            hi_reg  <= hi_next;
            sig_reg <= sig_next;
            err_reg <= err_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_lo    = lo_reg;
    assign out_hi    = hi_reg;
    assign out_sig   = sig_reg;
    assign out_err   = err_reg;

endmodule

`default_nettype wire

/* hdl/multiply_divide_unit.sv */
// Top level of the x86-style MUL/IMUL/DIV/IDIV unit.
// Instantiates mdu_front, mdu_queue and mdu_back; uses mdu_pkg.
//
//  channel | dir | handshake         | payload
//  s_      | in  | s_tvalid/s_tready | tuser: action, width_select; tdata: operands
//  m_      | out | m_tvalid/m_tready | tdata: out_low, out_high, flags
//
// One request per cycle sustained while m_tready is high. From acceptance
// to m_tvalid: queue, multiply stage, 32 divide stages, output register.
// Every operation runs the full divide pipeline so results stay in order.
// Synchronous active-low reset empties queue and pipeline.
// A stall on m_tready freezes the pipeline; the queue keeps taking requests
// until its two entries are full.
`default_nettype none

module multiply_divide_unit
    import mdu_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [95:0]  s_tdata,   // source_operand, acc_low, acc_high
    input  wire logic [3:0]   s_tuser,   // action, width_select
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [71:0]       m_tdata    // out_low, out_high, upper_significant,
                                         // divide_error, 6 zero bits
);

    mdu_item_t   f_item;
    mdu_item_t   q_item;
    logic        q_full;
    logic        q_valid;
    logic        q_pop;
    logic [31:0] out_lo;
    logic [31:0] out_hi;
    logic        out_sig;
    logic        out_err;

    assign s_tready = !q_full;

    mdu_front u_front (
        .action (s_tuser[1:0]),
        .wsel   (s_tuser[3:2]),
        .src    (s_tdata[31:0]),
        .acc_lo (s_tdata[63:32]),
        .acc_hi (s_tdata[95:64]),
        .item   (f_item)
    );

    mdu_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (s_tvalid),
        .wr_item  (f_item),
        .full     (q_full),
        .rd_en    (q_pop),
        .rd_valid (q_valid),
        .rd_item  (q_item)
    );

    mdu_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (q_valid),
        .in_item   (q_item),
        .in_pop    (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_lo    (out_lo),
        .out_hi    (out_hi),
        .out_sig   (out_sig),
        .out_err   (out_err)
    );

    assign m_tdata = {6'd0, out_err, out_sig, out_hi, out_lo};

endmodule

`default_nettype wire

/* hdl/mdu_checker.sv */
// Port-level checks for multiply_divide_unit, attached by bind.
// Depends only on the top level's ports.
`default_nettype none

module mdu_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic [95:0]  s_tdata,
    input wire logic [3:0]   s_tuser,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [71:0]  m_tdata
);

    // waiting request holds
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
        else $error("request changed while waiting");

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // a result is either a multiply or a divide, never flagged both ways
    a_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[64] && m_tdata[65]))
        else $error("both result flags set");

    // pad bits stay zero
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[71:66] == 6'd0)
        else $error("pad bits set");

    // reset empties the pipeline
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind multiply_divide_unit mdu_checker u_mdu_checker (.*);

`default_nettype wire

/* bench/multiply_divide_unit_checker.sv */
// Result checker for the multiply/divide unit: watches both stream channels,
// predicts each result from the accepted request and compares in order.
// Depends on mdu_pkg for the action codes and width selects.
`default_nettype none

module multiply_divide_unit_checker
    import mdu_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    input  wire logic         s_tready,
    input  wire logic [95:0]  s_tdata,
    input  wire logic [3:0]   s_tuser,
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic [71:0]  m_tdata,
    output int                fail_count,
    output int                pending_count,
    output int                result_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] lo;
        logic [31:0] hi;
        logic        sig;
        logic        err;
    } mdu_result_t;

    mdu_result_t expected_results[$];

    function automatic mdu_result_t compute_result(input logic [1:0] act_bits,
                                                   input logic [1:0] wsel,
                                                   input logic [31:0] src_in,
                                                   input logic [31:0] lo_in,
                                                   input logic [31:0] hi_in);
        mdu_action_t act;
        int unsigned w;
        logic [63:0] m, m2, s, lo, hi, p, dvd, q, r, mag_n, mag_d, lim;
        logic        neg_n, neg_d, neg_q;
        mdu_result_t res;
        act = mdu_action_t'(act_bits);
        w = (wsel == WSEL_8) ? 8 : (wsel == WSEL_16) ? 16 : 32;
        m = (64'd1 << w) - 1;
        m2 = (w == 32) ? '1 : ((64'd1 << (2 * w)) - 1);
        s = src_in & m;
        lo = lo_in & m;
        hi = hi_in & m;
        res = '0;
        if (act == ACT_MULU || act == ACT_MULS) begin
            if (act == ACT_MULU) begin
                p = lo * s;
            end else begin
                if (lo[w-1]) lo = lo | ~m;
                if (s[w-1]) s = s | ~m;
                p = lo * s;
            end
            res.lo = 32'(p & m);
            res.hi = 32'((p >> w) & m);
            if (act == ACT_MULU) res.sig = (res.hi != 0);
            else res.sig = (res.hi != (res.lo[w-1] ? m[31:0] : 32'd0));
        end else begin
            dvd = ((hi << w) | lo) & m2;
            if (s == 0) begin
                res.err = 1'b1;
            end else if (act == ACT_DIVU) begin
                q = dvd / s;
                if (q > m) res.err = 1'b1;
                else begin
                    res.lo = 32'(q);
                    res.hi = 32'(dvd % s);
                end
            end else begin
                neg_n = dvd[2*w-1];
                neg_d = s[w-1];
                mag_n = neg_n ? ((~dvd + 1) & m2) : dvd;
                mag_d = neg_d ? ((~s + 1) & m) : s;
                q = mag_n / mag_d;
                r = mag_n % mag_d;
                neg_q = neg_n != neg_d;
                lim = 64'd1 << (w - 1);
                if (neg_q ? (q > lim) : (q > lim - 1)) res.err = 1'b1;
                else begin
                    res.lo = 32'((neg_q ? (~q + 1) : q) & m);
                    res.hi = 32'((neg_n ? (~r + 1) : r) & m);
                end
            end
            if (res.err) begin
                res.lo = lo_in;
                res.hi = hi_in;
            end
        end
        return res;
    endfunction

    assign pending_count = expected_results.size();

    always @(posedge aclk) begin
        mdu_result_t want, got;
        if (!aresetn) begin
            fail_count <= 0;
            result_count <= 0;
            expected_results.delete();
        end else begin
            if (s_tvalid && s_tready)
                expected_results.push_back(compute_result(s_tuser[1:0], s_tuser[3:2],
                    s_tdata[31:0], s_tdata[63:32], s_tdata[95:64]));
            if (m_tvalid && m_tready) begin
                got.lo = m_tdata[31:0];
                got.hi = m_tdata[63:32];
                got.sig = m_tdata[64];
                got.err = m_tdata[65];
                result_count <= result_count + 1;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result lo=%h hi=%h sig=%b err=%b",
                             $time, got.lo, got.hi, got.sig, got.err);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch expected lo=%h hi=%h sig=%b err=%b",
                                 $time, want.lo, want.hi, want.sig, want.err);
                        $display("%0t:          actual   lo=%h hi=%h sig=%b err=%b",
                                 $time, got.lo, got.hi, got.sig, got.err);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

/* bench/multiply_divide_unit_tb.sv */
// Testbench top for the multiply/divide unit: clock, reset, request stimulus,
// output backpressure and verdict. Uses mdu_pkg and multiply_divide_unit_checker.
`default_nettype none

module multiply_divide_unit_tb
    import mdu_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_REQUESTS = 730;
    localparam int IDLE_LIMIT = 2000;
    localparam int LATENCY = 34;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata = '0;
    logic [3:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    int          fail_count, pending_count, result_count;
    bit          requests_done = 1'b0;
    bit          long_holdoff = 1'b0;
    int          idle_cycles = 0;
    int          sent_count = 0;

    always #6 aclk = ~aclk;

    multiply_divide_unit DUT (.*);

    multiply_divide_unit_checker checker_inst (.*);

    // one request: after an optional random gap with valid low, hold until accepted
    task automatic send_request(input mdu_action_t act, input logic [1:0] wsel,
                                input logic [31:0] src, input logic [31:0] lo,
                                input logic [31:0] hi);
        int gap;
        gap = $urandom_range(0, 19);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0 && s_tvalid) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= {wsel, logic'(act[1]), logic'(act[0])};
        s_tdata <= {hi, lo, src};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent_count++;
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000 >> (8 * $urandom_range(0, 3));
            3: return $urandom_range(0, 20);
            default: return $urandom;
        endcase
    endfunction

    // receiver: random stalls, plus one long hold-off while requests pile up
    initial begin
        int stall;
        @(posedge aclk iff aresetn);
        forever begin
            if (long_holdoff) begin
                m_tready <= 1'b0;
                repeat (300) @(posedge aclk);
                long_holdoff = 1'b0;
            end
            stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 19);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else if (aresetn && !(requests_done && pending_count == 0))
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        logic [31:0] src, lo, hi;
        logic [1:0]  wsel;
        mdu_action_t act;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes, all operations and widths, error cases
        for (int a = 0; a < 4; a++) begin
            send_request(mdu_action_t'(a), WSEL_8, 32'hFFFF_FF80, 32'hFFFF_FF80, 32'hFFFF_FFFF);
            send_request(mdu_action_t'(a), WSEL_16, 32'h0000_0000, 32'hFFFF_FFFF, 32'h1234_0000);
            send_request(mdu_action_t'(a), WSEL_32,
                         32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000);
            send_request(mdu_action_t'(a), WSEL_ALT,
                         32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
        end
        send_request(ACT_DIVS, WSEL_8, 32'h0000_00FF, 32'h0000_0080, 32'h0000_00FF);
        send_request(ACT_DIVS, WSEL_16, 32'h0000_FFFF, 32'h0000_0000, 32'h0000_8000);
        send_request(ACT_DIVS, WSEL_32, 32'h0000_0002, 32'h0000_0000, 32'hC000_0000);
        send_request(ACT_DIVS, WSEL_32, 32'hFFFF_FFFE, 32'h0000_0000, 32'h4000_0000);
        send_request(ACT_DIVU, WSEL_8, 32'h0000_0001, 32'h0000_00FF, 32'h0000_0000);
        send_request(ACT_DIVU, WSEL_16, 32'hABCD_0007, 32'hFFFF_1234, 32'hFFFF_0006);
        send_request(ACT_MULS, WSEL_16, 32'h0000_8000, 32'h0000_8000, 32'h0);

        for (int i = 0; i < RANDOM_REQUESTS; i++) begin
            if (i == 200) long_holdoff = 1'b1;
            if (i == 400) begin
                // drain completely before continuing
                s_tvalid <= 1'b0;
                @(posedge aclk);
                while (pending_count != 0) @(posedge aclk);
            end
            act = mdu_action_t'($urandom_range(0, 3));
            wsel = 2'($urandom_range(0, 3));
            src = pick_value();
            lo = pick_value();
            hi = pick_value();
            // keep many divides in range: small high half relative to divisor
            if ((act == ACT_DIVU || act == ACT_DIVS) && $urandom_range(0, 2) != 0) begin
                if ($urandom_range(0, 1)) hi = hi & 32'h0000_00FF;
                else hi = {32{lo[31]}};
            end
            send_request(act, wsel, src, lo, hi);
        end
        s_tvalid <= 1'b0;
        requests_done = 1'b1;
        while (pending_count != 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
        $display("sent %0d requests across all four operations and widths, %0d results checked",
                 sent_count, result_count);
        $display("including divide errors, sign extremes and long output stalls");
        if (fail_count == 0 && pending_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
